### src/ftl_pkg.sv
// Package for the four-phase traffic light controller.
// Holds the phase and register codes, the shared structs and the display helpers.
// Used by every module in src; depends on nothing.
package ftl_pkg;

  // Phase codes.
  localparam logic [1:0] PHASE_NS_GREEN  = 2'd0;
  localparam logic [1:0] PHASE_NS_YELLOW = 2'd1;
  localparam logic [1:0] PHASE_EW_GREEN  = 2'd2;
  localparam logic [1:0] PHASE_EW_YELLOW = 2'd3;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] REG_NS_GREEN_SECS    = 2'd1;
  localparam logic [1:0] REG_EW_GREEN_SECS    = 2'd2;
  localparam logic [1:0] REG_YELLOW_LOAD      = 2'd3;

  // Lamp bits: bit0 red, bit1 yellow, bit2 green.
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b100;

  // Reset values.
  localparam logic [9:0] RST_TICKS_PER_SECOND = 10'd20;
  localparam logic [6:0] RST_NS_GREEN_SECS    = 7'd50;
  localparam logic [6:0] RST_EW_GREEN_SECS    = 7'd50;
  localparam logic [3:0] RST_YELLOW_LOAD      = 4'd10;
  localparam logic [6:0] RST_NS_COUNT         = 7'd50;
  localparam logic [6:0] RST_EW_COUNT         = 7'd60;

  // Largest count the two-digit display can show.
  localparam logic [6:0] MAX_COUNT = 7'd99;

  // Configuration register contents.
  typedef struct packed {
    logic [9:0] ticks_per_second;
    logic [6:0] ns_green_secs;
    logic [6:0] ew_green_secs;
    logic [3:0] yellow_load;
  } cfg_t;

  // Controller state reported after one word.
  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] ns_count;
    logic [6:0] ew_count;
  } step_t;

  // Clamp a loaded count to the display range.
  function automatic logic [6:0] sat_load(input logic [7:0] v);
    logic [6:0] r;
    if (v > {1'b0, MAX_COUNT}) begin
      r = MAX_COUNT;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  // Tens digit modulo ten; v*205>>11 equals v/10 for every 7-bit v.
  function automatic logic [3:0] tens_digit(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    if (q >= 4'd10) begin
      q = q - 4'd10;
    end
    return q;
  endfunction

  // Ones digit: what remains after the exact quotient times ten.
  function automatic logic [3:0] ones_digit(input logic [6:0] v);
    logic [14:0] prod;
    logic [6:0]  q10;
    logic [6:0]  rem;
    prod = 15'(v) * 15'd205;
    q10  = 7'(prod[14:11]) * 7'd10;
    rem  = v - q10;
    return rem[3:0];
  endfunction

  // Seven-segment code, gfedcba, for one decimal digit.
  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // North-south lamps for a phase.
  function automatic logic [2:0] ns_lamps(input logic [1:0] p);
    logic [2:0] l;
    unique case (p)
      PHASE_NS_GREEN:  l = LAMP_GREEN;
      PHASE_NS_YELLOW: l = LAMP_YELLOW;
      PHASE_EW_GREEN:  l = LAMP_RED;
      PHASE_EW_YELLOW: l = LAMP_RED;
    endcase
    return l;
  endfunction

  // East-west lamps for a phase.
  function automatic logic [2:0] ew_lamps(input logic [1:0] p);
    logic [2:0] l;
    unique case (p)
      PHASE_NS_GREEN:  l = LAMP_RED;
      PHASE_NS_YELLOW: l = LAMP_RED;
      PHASE_EW_GREEN:  l = LAMP_GREEN;
      PHASE_EW_YELLOW: l = LAMP_YELLOW;
    endcase
    return l;
  endfunction

endpackage

### src/ftl_regs.sv
// Configuration register file of the traffic light controller, on an APB-style port.
// Depends on ftl_pkg for the register indexes, reset values and cfg_t.
module ftl_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ftl_pkg::cfg_t cfg_o
);

  ftl_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second <= ftl_pkg::RST_TICKS_PER_SECOND;
      cfg_q.ns_green_secs    <= ftl_pkg::RST_NS_GREEN_SECS;
      cfg_q.ew_green_secs    <= ftl_pkg::RST_EW_GREEN_SECS;
      cfg_q.yellow_load      <= ftl_pkg::RST_YELLOW_LOAD;
    end else if (wr_en) begin
      unique case (reg_idx)
        ftl_pkg::REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= pwdata[9:0];
        ftl_pkg::REG_NS_GREEN_SECS:    cfg_q.ns_green_secs    <= pwdata[6:0];
        ftl_pkg::REG_EW_GREEN_SECS:    cfg_q.ew_green_secs    <= pwdata[6:0];
        ftl_pkg::REG_YELLOW_LOAD:      cfg_q.yellow_load      <= pwdata[3:0];
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      ftl_pkg::REG_TICKS_PER_SECOND: prdata = 32'(cfg_q.ticks_per_second);
      ftl_pkg::REG_NS_GREEN_SECS:    prdata = 32'(cfg_q.ns_green_secs);
      ftl_pkg::REG_EW_GREEN_SECS:    prdata = 32'(cfg_q.ew_green_secs);
      ftl_pkg::REG_YELLOW_LOAD:      prdata = 32'(cfg_q.yellow_load);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### src/ftl_step.sv
// Phase sequencer of the traffic light controller: prescaler, countdowns and phase.
// Depends on ftl_pkg for the phase codes, cfg_t, step_t and sat_load.
module ftl_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           tick_i,
  input  ftl_pkg::cfg_t  cfg_i,
  output ftl_pkg::step_t next_o
);

  logic [1:0]  phase_q, phase_d;
  logic [9:0]  presc_q, presc_d;
  logic [6:0]  ns_q, ns_d;
  logic [6:0]  ew_q, ew_d;
  logic [9:0]  act_tps_q, act_tps_d;
  logic [3:0]  act_yel_q, act_yel_d;

  logic [10:0] presc_inc;
  logic        sec_done;
  logic [9:0]  presc_t;
  logic [6:0]  ns_t, ew_t;
  logic        yellow_done;

  // Prescaler and one-second countdown step.
  always_comb begin
    presc_inc = {1'b0, presc_q} + 11'd1;
    sec_done  = tick_i && (presc_inc >= {1'b0, act_tps_q});
    if (!tick_i) begin
      presc_t = presc_q;
    end else if (sec_done) begin
      presc_t = '0;
    end else begin
      presc_t = presc_inc[9:0];
    end
    ns_t = (sec_done && (ns_q != '0)) ? ns_q - 7'd1 : ns_q;
    ew_t = (sec_done && (ew_q != '0)) ? ew_q - 7'd1 : ew_q;
    yellow_done = (ns_t <= 7'd1) && (ew_t <= 7'd1);
  end

  // Phase transitions; a green entry latches the timing registers.
  always_comb begin
    phase_d   = phase_q;
    presc_d   = presc_t;
    ns_d      = ns_t;
    ew_d      = ew_t;
    act_tps_d = act_tps_q;
    act_yel_d = act_yel_q;
    unique case (phase_q)
      ftl_pkg::PHASE_NS_GREEN: begin
        if (ns_t == '0) begin
          ns_d    = ftl_pkg::sat_load({4'b0, act_yel_q});
          phase_d = ftl_pkg::PHASE_NS_YELLOW;
        end
      end
      ftl_pkg::PHASE_NS_YELLOW: begin
        if (yellow_done) begin
          act_tps_d = cfg_i.ticks_per_second;
          act_yel_d = cfg_i.yellow_load;
          ns_d      = ftl_pkg::sat_load({1'b0, cfg_i.ew_green_secs}
                                        + {4'b0, cfg_i.yellow_load});
          ew_d      = ftl_pkg::sat_load({1'b0, cfg_i.ew_green_secs});
          presc_d   = '0;
          phase_d   = ftl_pkg::PHASE_EW_GREEN;
        end
      end
      ftl_pkg::PHASE_EW_GREEN: begin
        if (ew_t == '0) begin
          ew_d    = ftl_pkg::sat_load({4'b0, act_yel_q});
          phase_d = ftl_pkg::PHASE_EW_YELLOW;
        end
      end
      ftl_pkg::PHASE_EW_YELLOW: begin
        if (yellow_done) begin
          act_tps_d = cfg_i.ticks_per_second;
          act_yel_d = cfg_i.yellow_load;
          ns_d      = ftl_pkg::sat_load({1'b0, cfg_i.ns_green_secs});
          ew_d      = ftl_pkg::sat_load({1'b0, cfg_i.ns_green_secs}
                                        + {4'b0, cfg_i.yellow_load});
          presc_d   = '0;
          phase_d   = ftl_pkg::PHASE_NS_GREEN;
        end
      end
    endcase
  end

  // State registers advance once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ftl_pkg::PHASE_NS_GREEN;
      presc_q   <= '0;
      ns_q      <= ftl_pkg::RST_NS_COUNT;
      ew_q      <= ftl_pkg::RST_EW_COUNT;
      act_tps_q <= ftl_pkg::RST_TICKS_PER_SECOND;
      act_yel_q <= ftl_pkg::RST_YELLOW_LOAD;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      presc_q   <= presc_d;
      ns_q      <= ns_d;
      ew_q      <= ew_d;
      act_tps_q <= act_tps_d;
      act_yel_q <= act_yel_d;
    end
  end

  assign next_o.phase    = phase_d;
  assign next_o.ns_count = ns_d;
  assign next_o.ew_count = ew_d;

`ifndef SYNTHESIS
  // The phase only ever moves on to the next one in the cycle.
  a_phase_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q)) |-> (phase_q == $past(phase_q) + 2'd1))
    else $error("phase skipped or went backward");

  // Both countdowns stay within the display range.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ns_q <= ftl_pkg::MAX_COUNT) && (ew_q <= ftl_pkg::MAX_COUNT))
    else $error("countdown above display range");

  // The prescaler stays below the latched ticks per second, or at zero.
  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (presc_q < act_tps_q) || (presc_q == '0))
    else $error("prescaler ran past its limit");

  // A green entry always starts a fresh second.
  a_green_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (phase_q != phase_d) && !phase_d[0]) |=> (presc_q == '0))
    else $error("prescaler not cleared at green entry");
`endif

endmodule

### src/ftl_out.sv
// Result register of the traffic light controller: lamps, flags, counts and digit codes.
// Depends on ftl_pkg for step_t, the phase codes and the display functions.
module ftl_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  ftl_pkg::step_t next_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [1:0]     phase_o,
  output logic [2:0]     ns_lamps_o,
  output logic [2:0]     ew_lamps_o,
  output logic           ns_flag_o,
  output logic           ew_flag_o,
  output logic [6:0]     ns_count_o,
  output logic [6:0]     ew_count_o,
  output logic [6:0]     seg_ns_tens_o,
  output logic [6:0]     seg_ns_ones_o,
  output logic [6:0]     seg_ew_tens_o,
  output logic [6:0]     seg_ew_ones_o
);

  logic       valid_q, valid_d;
  logic [1:0] phase_q;
  logic [2:0] ns_lamps_q, ew_lamps_q;
  logic       ns_flag_q, ew_flag_q;
  logic [6:0] ns_count_q, ew_count_q;
  logic [6:0] seg_ns_tens_q, seg_ns_ones_q, seg_ew_tens_q, seg_ew_ones_q;

  // A new word fills the register; a taken word empties it.
  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Decode the new state into the display fields.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      phase_q       <= next_i.phase;
      ns_lamps_q    <= ftl_pkg::ns_lamps(next_i.phase);
      ew_lamps_q    <= ftl_pkg::ew_lamps(next_i.phase);
      ns_flag_q     <= (next_i.phase != ftl_pkg::PHASE_NS_GREEN);
      ew_flag_q     <= (next_i.phase != ftl_pkg::PHASE_EW_GREEN);
      ns_count_q    <= next_i.ns_count;
      ew_count_q    <= next_i.ew_count;
      seg_ns_tens_q <= ftl_pkg::seg7(ftl_pkg::tens_digit(next_i.ns_count));
      seg_ns_ones_q <= ftl_pkg::seg7(ftl_pkg::ones_digit(next_i.ns_count));
      seg_ew_tens_q <= ftl_pkg::seg7(ftl_pkg::tens_digit(next_i.ew_count));
      seg_ew_ones_q <= ftl_pkg::seg7(ftl_pkg::ones_digit(next_i.ew_count));
    end
  end

  assign out_valid_o   = valid_q;
  assign phase_o       = phase_q;
  assign ns_lamps_o    = ns_lamps_q;
  assign ew_lamps_o    = ew_lamps_q;
  assign ns_flag_o     = ns_flag_q;
  assign ew_flag_o     = ew_flag_q;
  assign ns_count_o    = ns_count_q;
  assign ew_count_o    = ew_count_q;
  assign seg_ns_tens_o = seg_ns_tens_q;
  assign seg_ns_ones_o = seg_ns_ones_q;
  assign seg_ew_tens_o = seg_ew_tens_q;
  assign seg_ew_ones_o = seg_ew_ones_q;

`ifndef SYNTHESIS
  // Every accepted word shows up as a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> valid_q)
    else $error("accepted word produced no result");

  // A waiting result is never overwritten without being taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !accept_i)
    else $error("result overwritten while stalled");
`endif

endmodule

### src/four_phase_traffic_light_controller.sv
// Channel   Handshake                        Payload
// in        in_valid_i / in_ready_o          tick_i
// out       out_valid_o / out_ready_i        phase, lamps, flags, counts, segment codes
// cfg       psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One word per clock cycle unless the output stalls: the sequencer update and the
// display decode sit between the state registers and a single result register.
// A result appears in the cycle after its word is accepted.
// in_ready_o is high whenever the result register is empty or is being taken.
// Reset (rst_ni low, asynchronous) starts in north-south green at 50/60 seconds.
// Register writes reach the running timing at the next green entry.
module four_phase_traffic_light_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  phase_o,
  output logic [2:0]  ns_lamps_o,
  output logic [2:0]  ew_lamps_o,
  output logic        ns_flag_o,
  output logic        ew_flag_o,
  output logic [6:0]  ns_count_o,
  output logic [6:0]  ew_count_o,
  output logic [6:0]  seg_ns_tens_o,
  output logic [6:0]  seg_ns_ones_o,
  output logic [6:0]  seg_ew_tens_o,
  output logic [6:0]  seg_ew_ones_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ftl_pkg::cfg_t  cfg;
  ftl_pkg::step_t step_next;
  logic           accept;

  // Take a word whenever the result register can hold its result.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ftl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ftl_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .tick_i   (tick_i),
    .cfg_i    (cfg),
    .next_o   (step_next)
  );

  ftl_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .next_i        (step_next),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .phase_o       (phase_o),
    .ns_lamps_o    (ns_lamps_o),
    .ew_lamps_o    (ew_lamps_o),
    .ns_flag_o     (ns_flag_o),
    .ew_flag_o     (ew_flag_o),
    .ns_count_o    (ns_count_o),
    .ew_count_o    (ew_count_o),
    .seg_ns_tens_o (seg_ns_tens_o),
    .seg_ns_ones_o (seg_ns_ones_o),
    .seg_ew_tens_o (seg_ew_tens_o),
    .seg_ew_ones_o (seg_ew_ones_o)
  );

`ifndef SYNTHESIS
  // The input side never stalls while the result register is free.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // Configuration accesses always complete at once.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable) |-> pready)
    else $error("configuration access stalled");

  // Lamps and direction flags agree on which side has green.
  a_flag_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!ns_flag_o == (ns_lamps_o == ftl_pkg::LAMP_GREEN))
                     && (!ew_flag_o == (ew_lamps_o == ftl_pkg::LAMP_GREEN))))
    else $error("direction flag disagrees with lamps");
`endif

endmodule
